// ===== rtl/ears_pkg.sv =====
package ears_pkg;

  localparam int QUO_W = 62;
  localparam int NUM_W = 72;
  localparam int LANES = 4;

  localparam int LANE_FIRST = 0;
  localparam int LANE_TAN   = 1;
  localparam int LANE_CX    = 2;
  localparam int LANE_CY    = 3;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh26DD3B6A;
  localparam logic [62:0]        CAP_MAG     = 63'(1) << 62;
  localparam logic [126:0]       WARN_LIMIT  = 127'(400) << 88;
  localparam logic [31:0]        STEP_RESET  = 32'd4294967;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  typedef struct packed {
    rot_t               pitch;
    rot_t               yaw;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } cord_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [31:0]      den;
    logic             cap;
    logic [31:0]      rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic               neg_a;
    logic               neg_b;
    logic               neg_s;
    logic               neg_cy;
    logic               fault;
    logic signed [31:0] wz;
    logic [40:0]        m1;
  } side_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    side_t             side;
  } div_t;

endpackage

// ===== rtl/ears_cordic_cell.sv =====
module ears_cordic_cell
  import ears_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cord_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cord_t out_data
);

  localparam logic signed [33:0] ANGLE = 34'(ATAN_Q30[STAGE]);

  function automatic rot_t rotate(rot_t r);
    rot_t               o;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = r.x >>> STAGE;
    ys = r.y >>> STAGE;
    o  = r;
    if (r.z >= 0) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - ANGLE;
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + ANGLE;
    end
    return o;
  endfunction

  cord_t nxt;

  always_comb begin
    nxt       = in_data;
    nxt.pitch = rotate(in_data.pitch);
    nxt.yaw   = rotate(in_data.yaw);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== rtl/ears_div_cell.sv =====
module ears_div_cell
  import ears_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  div_t        nxt;
  logic [32:0] trial [LANES];

  always_comb begin
    nxt = in_data;
    for (int k = 0; k < LANES; k++) begin
      trial[k] = {in_data.lane[k].rem, in_data.lane[k].num[QUO_W-1]};
      nxt.lane[k].num = {in_data.lane[k].num[NUM_W-2:0], 1'b0};
      if (trial[k] >= {1'b0, in_data.lane[k].den}) begin
        nxt.lane[k].rem = 32'(trial[k] - {1'b0, in_data.lane[k].den});
        nxt.lane[k].quo = {in_data.lane[k].quo[QUO_W-2:0], 1'b1};
      end else begin
        nxt.lane[k].rem = trial[k][31:0];
        nxt.lane[k].quo = {in_data.lane[k].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== rtl/ears_front.sv =====
module ears_front
  import ears_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cord_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output div_t  out_data
);

  typedef struct packed {
    logic signed [63:0] pxc;
    logic signed [63:0] pys;
    logic signed [63:0] pxs;
    logic signed [63:0] pyc;
    logic signed [31:0] sy;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] wz;
  } prod_t;

  typedef struct packed {
    logic [62:0]        ma;
    logic [62:0]        mb;
    logic [31:0]        ms;
    logic [31:0]        mcy;
    logic [31:0]        mcz;
    logic               neg_a;
    logic               neg_b;
    logic               neg_s;
    logic               neg_cy;
    logic signed [31:0] wz;
  } mag_t;

  typedef struct packed {
    logic [63:0] as_lo;
    logic [62:0] as_hi;
    logic [63:0] bs_lo;
    logic [62:0] bs_hi;
    mag_t        m;
  } part_t;

  function automatic lane_t make_lane(logic [NUM_W-1:0] num, logic [31:0] den, logic nz);
    lane_t l;
    l.num = num;
    l.den = den;
    l.cap = (den == '0) ? nz : (32'(num[NUM_W-1:QUO_W]) >= den);
    l.rem = 32'(num[NUM_W-1:QUO_W]);
    l.quo = '0;
    return l;
  endfunction

  logic  v1, v2, v3;
  logic  r1, r2, r3, r4;
  prod_t s1, s1_next;
  mag_t  s2, s2_next;
  part_t s3, s3_next;
  div_t  s4_next;

  logic signed [31:0] sy, cy, sz, cz;
  logic signed [63:0] a_val, b_val;
  logic [94:0]        prod_a, prod_b;

  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    sy = 32'(in_data.pitch.flip ? -in_data.pitch.y : in_data.pitch.y);
    cy = 32'(in_data.pitch.flip ? -in_data.pitch.x : in_data.pitch.x);
    sz = 32'(in_data.yaw.flip ? -in_data.yaw.y : in_data.yaw.y);
    cz = 32'(in_data.yaw.flip ? -in_data.yaw.x : in_data.yaw.x);
    s1_next.pxc = in_data.wx * cz;
    s1_next.pys = in_data.wy * sz;
    s1_next.pxs = in_data.wx * sz;
    s1_next.pyc = in_data.wy * cz;
    s1_next.sy  = sy;
    s1_next.cy  = cy;
    s1_next.cz  = cz;
    s1_next.wz  = in_data.wz;
  end

  always_comb begin
    a_val          = s1.pxc - s1.pys;
    b_val          = s1.pxs + s1.pyc;
    s2_next.neg_a  = a_val[63];
    s2_next.neg_b  = b_val[63];
    s2_next.neg_s  = s1.sy[31];
    s2_next.neg_cy = s1.cy[31];
    s2_next.ma     = 63'(a_val[63] ? -a_val : a_val);
    s2_next.mb     = 63'(b_val[63] ? -b_val : b_val);
    s2_next.ms     = 32'(s1.sy[31] ? -s1.sy : s1.sy);
    s2_next.mcy    = 32'(s1.cy[31] ? -s1.cy : s1.cy);
    s2_next.mcz    = 32'(s1.cz[31] ? -s1.cz : s1.cz);
    s2_next.wz     = s1.wz;
  end

  always_comb begin
    s3_next.as_lo = 64'(s2.ma[31:0]) * 64'(s2.ms);
    s3_next.as_hi = 63'(s2.ma[62:32]) * 63'(s2.ms);
    s3_next.bs_lo = 64'(s2.mb[31:0]) * 64'(s2.ms);
    s3_next.bs_hi = 63'(s2.mb[62:32]) * 63'(s2.ms);
    s3_next.m     = s2;
  end

  always_comb begin
    prod_a = (95'(s3.as_hi) << 32) + 95'(s3.as_lo);
    prod_b = (95'(s3.bs_hi) << 32) + 95'(s3.bs_lo);
    s4_next.lane[LANE_FIRST] = make_lane({1'b0, s3.m.ma, 8'b0}, s3.m.mcy, |s3.m.ma);
    s4_next.lane[LANE_TAN]   = make_lane(prod_a[93:22], s3.m.mcy, |prod_a);
    s4_next.lane[LANE_CX]    = make_lane({1'b0, s3.m.mb, 8'b0}, s3.m.mcz, |s3.m.mb);
    s4_next.lane[LANE_CY]    = make_lane(prod_b[93:22], s3.m.mcy, |prod_b);
    s4_next.side.neg_a       = s3.m.neg_a;
    s4_next.side.neg_b       = s3.m.neg_b;
    s4_next.side.neg_s       = s3.m.neg_s;
    s4_next.side.neg_cy      = s3.m.neg_cy;
    s4_next.side.fault       = (s3.m.mcy == '0) || (s3.m.mcz == '0);
    s4_next.side.wz          = s3.m.wz;
    s4_next.side.m1          = s3.m.mb[62:22];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) s1 <= s1_next;
    if (r2 && v1) s2 <= s2_next;
    if (r3 && v2) s3 <= s3_next;
    if (r4 && v3) out_data <= s4_next;
  end

endmodule

// ===== rtl/ears_back.sv =====
module ears_back
  import ears_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] step,
  input  logic [63:0] step_sq,
  input  logic        in_valid,
  output logic        in_ready,
  input  div_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] delta_first,
  output logic [31:0] delta_second,
  output logic [31:0] delta_third,
  output logic        warn_first,
  output logic        warn_third,
  output logic        divide_fault
);

  typedef struct packed {
    logic [2:0][62:0] mg;
    logic [2:0]       neg;
    logic [62:0]      cx;
    logic [62:0]      cy;
    logic             fault;
  } fin_t;

  typedef struct packed {
    logic [2:0][63:0] lo;
    logic [2:0][62:0] hi;
    logic [1:0][63:0] w00;
    logic [1:0][63:0] w01;
    logic [1:0][62:0] w10;
    logic [1:0][62:0] w11;
    logic [2:0]       neg;
    logic             fault;
  } part_t;

  function automatic logic [62:0] lane_mag(lane_t l);
    return l.cap ? CAP_MAG : {1'b0, l.quo};
  endfunction

  function automatic logic [31:0] saturate(logic neg, logic [63:0] q);
    logic [31:0] t;
    if (neg) begin
      t = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
      return -t;
    end
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  logic  v1, v2;
  logic  r1, r2, r3;
  fin_t  s1, s1_next;
  part_t s2, s2_next;

  logic [62:0]        tm;
  logic signed [63:0] tsig, v2_val;
  logic [63:0]        q [3];
  logic [126:0]       w [2];
  logic [31:0]        d_next [3];
  logic [1:0]         warn_next;

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    tm     = lane_mag(in_data.lane[LANE_TAN]);
    tsig   = (in_data.side.neg_a ^ in_data.side.neg_s ^ in_data.side.neg_cy)
             ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
    v2_val = $signed({{24{in_data.side.wz[31]}}, in_data.side.wz, 8'b0}) - tsig;
    s1_next.mg[0]  = lane_mag(in_data.lane[LANE_FIRST]);
    s1_next.mg[1]  = 63'(in_data.side.m1);
    s1_next.mg[2]  = 63'(v2_val[63] ? -v2_val : v2_val);
    s1_next.neg[0] = in_data.side.neg_a ^ in_data.side.neg_cy;
    s1_next.neg[1] = in_data.side.neg_b;
    s1_next.neg[2] = v2_val[63];
    s1_next.cx     = lane_mag(in_data.lane[LANE_CX]);
    s1_next.cy     = lane_mag(in_data.lane[LANE_CY]);
    s1_next.fault  = in_data.side.fault;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_next.lo[k] = 64'(s1.mg[k][31:0]) * 64'(step);
      s2_next.hi[k] = 63'(s1.mg[k][62:32]) * 63'(step);
    end
    s2_next.w00[0] = 64'(s1.cx[31:0]) * 64'(step_sq[31:0]);
    s2_next.w01[0] = 64'(s1.cx[31:0]) * 64'(step_sq[63:32]);
    s2_next.w10[0] = 63'(s1.cx[62:32]) * 63'(step_sq[31:0]);
    s2_next.w11[0] = 63'(s1.cx[62:32]) * 63'(step_sq[63:32]);
    s2_next.w00[1] = 64'(s1.cy[31:0]) * 64'(step_sq[31:0]);
    s2_next.w01[1] = 64'(s1.cy[31:0]) * 64'(step_sq[63:32]);
    s2_next.w10[1] = 63'(s1.cy[62:32]) * 63'(step_sq[31:0]);
    s2_next.w11[1] = 63'(s1.cy[62:32]) * 63'(step_sq[63:32]);
    s2_next.neg    = s1.neg;
    s2_next.fault  = s1.fault;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k]      = 64'(s2.hi[k]) + 64'(s2.lo[k][63:32]);
      d_next[k] = saturate(s2.neg[k], q[k]);
    end
    for (int j = 0; j < 2; j++) begin
      w[j] = 127'(s2.w00[j]) + (127'(s2.w01[j]) << 32) + (127'(s2.w10[j]) << 32)
             + (127'(s2.w11[j]) << 64);
      warn_next[j] = w[j] > WARN_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) s1 <= s1_next;
    if (r2 && v1) s2 <= s2_next;
    if (r3 && v2) begin
      delta_first  <= d_next[0];
      delta_second <= d_next[1];
      delta_third  <= d_next[2];
      warn_first   <= warn_next[0];
      warn_third   <= warn_next[1];
      divide_fault <= s2.fault;
    end
  end

endmodule

// ===== rtl/euler_angle_rate_step_core.sv =====
// Euler angle rate step: each item carries pitch and yaw (Q4.28 rad) and three body rates
// (Q16.16 rad/s) and yields three angle increments scaled by the time step (Q8.24,
// saturating), two step-size warnings and a zero-cosine flag. One item is taken per clock
// unless the output stalls, and results leave in order after one CORDIC cell per stage for
// both angles, four multiply stages, a row of 62 divider cells that each settle one
// quotient bit for four quotients at once, and three scaling stages. Every stage holds its
// own item, so gaps close up while the output waits. The time step register should be
// written only while no item is in flight.
module euler_angle_rate_step_core
  import ears_pkg::*;
#(
  parameter int CORDIC_STAGES = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_pitch, angle_yaw, rate_x, rate_y, rate_z
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // delta_first, delta_second, delta_third, warn_first, warn_third, divide_fault
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  function automatic rot_t reduce(logic signed [31:0] a);
    rot_t               r;
    logic signed [34:0] z;
    logic               flip;
    z    = {a[31], a, 2'b00};
    flip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (z > HALF_PI_Q30) begin
        z    = z - PI_Q30;
        flip = !flip;
      end else if (z < -HALF_PI_Q30) begin
        z    = z + PI_Q30;
        flip = !flip;
      end
    end
    r.x    = CORDIC_GAIN;
    r.y    = '0;
    r.z    = z[33:0];
    r.flip = flip;
    return r;
  endfunction

  logic [31:0] time_step;
  logic [63:0] step_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= STEP_RESET;
    end else if (cfg_valid) begin
      time_step <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    step_sq <= 64'(time_step) * 64'(time_step);
  end

  cord_t c_data  [CORDIC_STAGES+1];
  logic  c_valid [CORDIC_STAGES+1];
  logic  c_ready [CORDIC_STAGES+1];

  always_comb begin
    c_data[0].pitch = reduce(s_axis_tdata[31:0]);
    c_data[0].yaw   = reduce(s_axis_tdata[63:32]);
    c_data[0].wx    = s_axis_tdata[95:64];
    c_data[0].wy    = s_axis_tdata[127:96];
    c_data[0].wz    = s_axis_tdata[159:128];
  end

  assign c_valid[0]    = s_axis_tvalid;
  assign s_axis_tready = c_ready[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ears_cordic_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_valid[i]),
      .in_ready (c_ready[i]),
      .in_data  (c_data[i]),
      .out_valid(c_valid[i+1]),
      .out_ready(c_ready[i+1]),
      .out_data (c_data[i+1])
    );
  end

  div_t d_data  [QUO_W+1];
  logic d_valid [QUO_W+1];
  logic d_ready [QUO_W+1];

  ears_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid[CORDIC_STAGES]),
    .in_ready (c_ready[CORDIC_STAGES]),
    .in_data  (c_data[CORDIC_STAGES]),
    .out_valid(d_valid[0]),
    .out_ready(d_ready[0]),
    .out_data (d_data[0])
  );

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    ears_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (d_valid[j]),
      .in_ready (d_ready[j]),
      .in_data  (d_data[j]),
      .out_valid(d_valid[j+1]),
      .out_ready(d_ready[j+1]),
      .out_data (d_data[j+1])
    );
  end

  logic [31:0] delta_first, delta_second, delta_third;
  logic        warn_first, warn_third, divide_fault;

  ears_back u_back (
    .clk         (clk),
    .rst         (rst),
    .step        (time_step),
    .step_sq     (step_sq),
    .in_valid    (d_valid[QUO_W]),
    .in_ready    (d_ready[QUO_W]),
    .in_data     (d_data[QUO_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .delta_first (delta_first),
    .delta_second(delta_second),
    .delta_third (delta_third),
    .warn_first  (warn_first),
    .warn_third  (warn_third),
    .divide_fault(divide_fault)
  );

  assign m_axis_tdata = {5'b0, divide_fault, warn_third, warn_first,
                         delta_third, delta_second, delta_first};

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_step_square: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> step_sq == 64'($past(time_step)) * 64'($past(time_step)))
    else $error("step square out of date");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while waiting");
`endif

endmodule

// ===== tb/euler_angle_rate_step_core_test.sv =====
module euler_angle_rate_step_core_test;
  import ears_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 28;
  localparam int DRAIN = STAGES + 69 + 60;
  localparam longint LIMIT_CYCLES = 600000;

  typedef struct {
    logic [31:0] d_first;
    logic [31:0] d_second;
    logic [31:0] d_third;
    logic        w_first;
    logic        w_third;
    logic        fault;
  } increment_t;

  typedef struct {
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
    bit          typed;
    increment_t  want;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  increment_t  pending[$];
  logic [31:0] step_h = STEP_RESET;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          warn_count = 0;
  int          fault_count = 0;
  longint      cycles = 0;

  euler_angle_rate_step_core #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic void sin_cos(input logic signed [31:0] ang,
                                  output longint s, output longint c);
    longint x, y, z, xs, ys;
    bit flip;
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = longint'(ang) * 4;
    flip = 0;
    for (int i = 0; i < 4; i++) begin
      if (z > longint'(HALF_PI_Q30)) begin
        z -= longint'(PI_Q30);
        flip = !flip;
      end else if (z < -longint'(HALF_PI_Q30)) begin
        z += longint'(PI_Q30);
        flip = !flip;
      end
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] capped_quotient(input logic [127:0] num,
                                                  input logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return (num != 0) ? 64'(CAP_MAG) : 64'd0;
    if (num[127:64] >= den) return 64'(CAP_MAG);
    q = num / den;
    return (q > 128'(CAP_MAG)) ? 64'(CAP_MAG) : q[63:0];
  endfunction

  function automatic logic [31:0] apply_step(input bit neg, input logic [63:0] m,
                                             input logic [31:0] h);
    logic [127:0] p;
    logic [63:0]  q;
    p = 128'(m) * 128'(h);
    q = p[95:32];
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(64'd0 - q);
    end
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic bit step_too_large(input logic [63:0] m, input logic [31:0] h);
    logic [63:0]  h2;
    logic [127:0] p;
    h2 = 64'(h) * 64'(h);
    p = 128'(m) * 128'(h2);
    return p > 128'(WARN_LIMIT);
  endfunction

  function automatic increment_t predict_increments(input row_t r, input logic [31:0] h);
    increment_t e;
    longint sy, cy, sz, cz, wx, wy, wz, a, b, t, v2;
    logic [63:0] ma, mb, ms, mcy, mcz, m0, m1, tm, m2, cx, cyv;
    bit na, nb, ns, ncy;
    sin_cos(r.pitch, sy, cy);
    sin_cos(r.yaw, sz, cz);
    wx = longint'(signed'(r.wx));
    wy = longint'(signed'(r.wy));
    wz = longint'(signed'(r.wz));
    a = wx * cz - wy * sz;
    b = wx * sz + wy * cz;
    ma = abs64(a); na = a < 0;
    mb = abs64(b); nb = b < 0;
    ms = abs64(sy); ns = sy < 0;
    mcy = abs64(cy); ncy = cy < 0;
    mcz = abs64(cz);
    m0 = capped_quotient(128'(ma) << 8, mcy);
    m1 = mb >> 22;
    tm = capped_quotient(128'(ma) * 128'(ms), mcy << 22);
    t = (na ^ ns ^ ncy) ? -longint'(tm) : longint'(tm);
    v2 = wz * 256 - t;
    m2 = abs64(v2);
    cx = capped_quotient(128'(mb) << 8, mcz);
    cyv = capped_quotient(128'(mb) * 128'(ms), mcy << 22);
    e.d_first = apply_step(na ^ ncy, m0, h);
    e.d_second = apply_step(nb, m1, h);
    e.d_third = apply_step(v2 < 0, m2, h);
    e.w_first = step_too_large(cx, h);
    e.w_third = step_too_large(cyv, h);
    e.fault = (mcy == 0) || (mcz == 0);
    return e;
  endfunction

  task automatic send_item(input row_t r);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {r.wz, r.wy, r.wx, r.yaw, r.pitch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending.push_back(r.typed ? r.want : predict_increments(r, step_h));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_step(input logic [31:0] v);
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    step_h = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic row_t random_row();
    row_t r;
    r.typed = 0;
    if ($urandom_range(3) == 0) begin
      r.pitch = $urandom; r.yaw = $urandom;
      r.wx = $urandom; r.wy = $urandom; r.wz = $urandom;
    end else begin
      r.pitch = 32'($signed($urandom_range(843314856)) - 421657428);
      r.yaw = 32'($signed($urandom_range(1686629712)) - 843314856);
      r.wx = 32'($signed($urandom_range(2000000)) - 1000000) <<< $urandom_range(8);
      r.wy = 32'($signed($urandom_range(2000000)) - 1000000) <<< $urandom_range(8);
      r.wz = 32'($signed($urandom_range(2000000)) - 1000000) <<< $urandom_range(8);
    end
    return r;
  endfunction

  function automatic row_t mk(input logic [31:0] p, y, x, w, z);
    row_t r;
    r.pitch = p; r.yaw = y; r.wx = x; r.wy = w; r.wz = z;
    r.typed = 0;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("euler_angle_rate_step_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    increment_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting: %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        warn_count += m_axis_tdata[96] | m_axis_tdata[97];
        fault_count += m_axis_tdata[98];
        if (m_axis_tdata[31:0] !== e.d_first) begin
          $error("delta_first expected %h actual %h", e.d_first, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.d_second) begin
          $error("delta_second expected %h actual %h", e.d_second, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tdata[95:64] !== e.d_third) begin
          $error("delta_third expected %h actual %h", e.d_third, m_axis_tdata[95:64]);
          errors++;
        end
        if (m_axis_tdata[96] !== e.w_first) begin
          $error("warn_first expected %b actual %b", e.w_first, m_axis_tdata[96]);
          errors++;
        end
        if (m_axis_tdata[97] !== e.w_third) begin
          $error("warn_third expected %b actual %b", e.w_third, m_axis_tdata[97]);
          errors++;
        end
        if (m_axis_tdata[98] !== e.fault) begin
          $error("divide_fault expected %b actual %b", e.fault, m_axis_tdata[98]);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    row_t table_rows[$];
    row_t r;
    logic [31:0] steps[5];
    int idles[5];
    int stalls[5];
    table_rows.push_back(mk(0, 0, 0, 0, 0));
    table_rows[0].typed = 1;
    table_rows[0].want = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0};
    table_rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF));
    table_rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
    table_rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
    table_rows.push_back(mk(32'd421657428, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    table_rows.push_back(mk(-32'sd421657428, 0, 32'h0010_0000, 0, 0));
    table_rows.push_back(mk(0, 32'd421657428, 32'h0001_0000, 32'h0002_0000, 0));
    table_rows.push_back(mk(32'd421657428, 32'd421657428, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    table_rows.push_back(mk(32'd421657429, 32'd421657427, 32'h0100_0000, 32'h0100_0000,
                            32'h0100_0000));
    table_rows.push_back(mk(32'd843314857, 32'd1264972285, 32'h0003_0000, 32'hFFFD_0000,
                            32'h0000_8000));
    table_rows.push_back(mk(32'd1686629713, -32'sd1686629713, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000));
    table_rows.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555));
    table_rows.push_back(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA));
    table_rows.push_back(mk(32'h1000_0000, 32'hF000_0000, 32'h7FFF_0000, 32'h0000_0001, 0));
    table_rows.push_back(mk(32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF));
    table_rows.push_back(mk(32'd421000000, 32'd100000000, 32'h0400_0000, 32'hFC00_0000,
                            32'h8000_0000));

    steps = '{STEP_RESET, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd42949673};
    steps[3] = $urandom;
    idles = '{0, 78, 0, 14, 0};
    stalls = '{0, 0, 78, 14, 0};

    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_step(steps[p]);
      send_idle = idles[p];
      recv_stall = stalls[p];
      if (p == 2) hold_left = 400;
      foreach (table_rows[i]) begin
        r = table_rows[i];
        if (p > 0) r.typed = 0;
        send_item(r);
      end
      for (int n = 0; n < 320; n++) send_item(random_row());
    end
    s_axis_tvalid <= 0;

    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d items over five time-step settings (reset, zero, maximum, random,",
             items_sent);
    $display("0.01 s); %0d results checked, %0d with warnings, %0d with divide faults.",
             results_seen, warn_count, fault_count);
    if (errors == 0 && pending.size() == 0) begin
      $display("euler_angle_rate_step_core: match");
    end else begin
      $display("euler_angle_rate_step_core: mismatch");
    end
    $finish;
  end

endmodule
